// ===== src/lasp_pkg.sv =====
// Shared types and constants for the LED animation stream parser.
// Depends on nothing; the parser, the output stage, the top level and the checker import it.
package lasp_pkg;

  // Kinds of result word.
  typedef enum logic [2:0] {
    KIND_HDR_OK     = 3'd0,
    KIND_HDR_REJECT = 3'd1,
    KIND_PIXEL      = 3'd2,
    KIND_ANIM_END   = 3'd3,
    KIND_TRUNCATED  = 3'd4
  } result_kind_t;

  // Header layout and frame codes.
  localparam int HdrTypeIdx    = 0;
  localparam int HdrVersionIdx = 5;
  localparam int HdrDepthIdx   = 6;
  localparam int HdrWidthHiIdx = 7;
  localparam int HdrWidthLoIdx = 8;
  localparam int HdrHeightHiIdx = 9;
  localparam int HdrHeightLoIdx = 10;
  localparam int HdrLastIdx    = 11;

  localparam logic [7:0] HdrType     = 8'd1;
  localparam logic [7:0] HdrVersion  = 8'd1;
  localparam logic [7:0] FrameType   = 8'd2;
  localparam logic [7:0] DepthMin    = 8'd2;
  localparam logic [7:0] DepthMax    = 8'd16;
  localparam int         MaxPixBytes = 6;

  // One result word as it travels from the parser to the output stage.
  typedef struct packed {
    result_kind_t kind;
    logic [7:0]   pixel_byte;
    logic         frame_first;
    logic         frame_last;
    logic [31:0]  show_time;
    logic [2:0]   pixel_bytes;
    logic [4:0]   colour_bits;
    logic         rewind_request;
  } lasp_result_t;

endpackage

// ===== src/lasp_if.sv =====
// Stream interfaces of the LED animation stream parser: input bytes and results.
// Depends on nothing; used by the top level.
interface lasp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

interface lasp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [7:0]  pixel_byte;
  logic        frame_first;
  logic        frame_last;
  logic [31:0] show_time;
  logic [2:0]  pixel_bytes;
  logic [4:0]  colour_bits;
  logic        rewind_request;

  modport source (output valid, output result_kind, output pixel_byte, output frame_first,
                  output frame_last, output show_time, output pixel_bytes,
                  output colour_bits, output rewind_request, input ready);
  modport sink   (input valid, input result_kind, input pixel_byte, input frame_first,
                  input frame_last, input show_time, input pixel_bytes,
                  input colour_bits, input rewind_request, output ready);
endinterface

// ===== src/lasp_parser.sv =====
// Parser state and per-byte decode: header check, frame phases, pixel counting.
// Depends on lasp_pkg; produces at most one result word per accepted byte.
module lasp_parser #(
  parameter int MATRIX_WIDTH  = 8,
  parameter int MATRIX_HEIGHT = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  first_byte,
  input  logic                  last_byte,
  input  logic                  repeat_enable,
  output logic                  res_valid,
  output lasp_pkg::lasp_result_t res
);
  import lasp_pkg::*;

  localparam int FramePixels = MATRIX_WIDTH * MATRIX_HEIGHT;
  localparam int MaxTotal    = MaxPixBytes * FramePixels;
  localparam int CntBits     = $clog2(MaxTotal + 1);
  localparam int CntW        = (CntBits < 4) ? 4 : CntBits;

  typedef enum logic [2:0] {
    PH_HEADER, PH_TYPE, PH_DHI, PH_DLO, PH_PIX, PH_IDLE
  } phase_t;

  phase_t          phase, phase_next;
  logic [CntW-1:0] byte_counter, byte_counter_next;
  logic            header_valid, header_valid_next;
  logic [7:0]      held_high_byte, held_high_byte_next;
  logic [4:0]      colour_depth, colour_depth_next;
  logic [2:0]      bytes_per_pixel, bytes_per_pixel_next;
  logic [15:0]     pending_delay, pending_delay_next;
  logic [31:0]     time_accumulator, time_accumulator_next;

  logic            emit;
  logic            rew;
  result_kind_t    kind;
  logic [7:0]      pix;
  logic            ff;
  logic            fl;
  logic [31:0]     show;
  logic [CntW-1:0] frame_total;
  logic            is_last;

  // Byte decode. A first byte restarts from the cleared state before decoding.
  always_comb begin
    phase_next            = phase;
    byte_counter_next     = byte_counter;
    header_valid_next     = header_valid;
    held_high_byte_next   = held_high_byte;
    colour_depth_next     = colour_depth;
    bytes_per_pixel_next  = bytes_per_pixel;
    pending_delay_next    = pending_delay;
    time_accumulator_next = time_accumulator;
    if (first_byte) begin
      phase_next            = PH_HEADER;
      byte_counter_next     = '0;
      header_valid_next     = 1'b1;
      held_high_byte_next   = '0;
      colour_depth_next     = '0;
      bytes_per_pixel_next  = '0;
      pending_delay_next    = '0;
      time_accumulator_next = '0;
    end
    show        = time_accumulator_next;
    emit        = 1'b0;
    rew         = 1'b0;
    kind        = KIND_HDR_OK;
    pix         = '0;
    ff          = 1'b0;
    fl          = 1'b0;
    frame_total = CntW'(bytes_per_pixel_next) * CntW'(FramePixels);
    is_last     = ({1'b0, byte_counter_next} + (CntW+1)'(1)) >= {1'b0, frame_total};

    case (phase_next)
      PH_HEADER: begin
        if (byte_counter_next == CntW'(HdrTypeIdx) && data_byte != HdrType) begin
          header_valid_next = 1'b0;
        end
        if (byte_counter_next == CntW'(HdrVersionIdx) && data_byte != HdrVersion) begin
          header_valid_next = 1'b0;
        end
        if (byte_counter_next == CntW'(HdrDepthIdx)) begin
          if (data_byte < DepthMin || data_byte > DepthMax) begin
            header_valid_next = 1'b0;
            colour_depth_next = '0;
          end else begin
            colour_depth_next = data_byte[4:0];
          end
        end
        if (byte_counter_next == CntW'(HdrWidthHiIdx) ||
            byte_counter_next == CntW'(HdrHeightHiIdx)) begin
          held_high_byte_next = data_byte;
        end
        if (byte_counter_next == CntW'(HdrWidthLoIdx) &&
            {held_high_byte_next, data_byte} != 16'(MATRIX_WIDTH)) begin
          header_valid_next = 1'b0;
        end
        if (byte_counter_next == CntW'(HdrHeightLoIdx) &&
            {held_high_byte_next, data_byte} != 16'(MATRIX_HEIGHT)) begin
          header_valid_next = 1'b0;
        end
        if (byte_counter_next >= CntW'(HdrLastIdx) && header_valid_next) begin
          // Good header: pick the pixel size from the colour depth.
          if (colour_depth_next > 5'd8) begin
            bytes_per_pixel_next = 3'd6;
          end else if (colour_depth_next > 5'd5) begin
            bytes_per_pixel_next = 3'd3;
          end else if (colour_depth_next > 5'd2) begin
            bytes_per_pixel_next = 3'd2;
          end else begin
            bytes_per_pixel_next = 3'd1;
          end
          emit              = 1'b1;
          kind              = KIND_HDR_OK;
          phase_next        = PH_TYPE;
          byte_counter_next = '0;
          if (last_byte) begin
            phase_next = repeat_enable ? PH_TYPE : PH_IDLE;
            rew        = repeat_enable;
          end
        end else if (byte_counter_next >= CntW'(HdrLastIdx) || last_byte) begin
          header_valid_next    = 1'b0;
          colour_depth_next    = '0;
          bytes_per_pixel_next = '0;
          phase_next           = PH_IDLE;
          byte_counter_next    = '0;
          emit                 = 1'b1;
          kind                 = KIND_HDR_REJECT;
        end else begin
          byte_counter_next = byte_counter_next + CntW'(1);
        end
      end
      PH_TYPE: begin
        if (data_byte != FrameType) begin
          emit = 1'b1;
          kind = KIND_ANIM_END;
        end else if (last_byte) begin
          emit = 1'b1;
          kind = KIND_TRUNCATED;
        end else begin
          phase_next = PH_DHI;
        end
      end
      PH_DHI: begin
        held_high_byte_next = data_byte;
        if (last_byte) begin
          emit = 1'b1;
          kind = KIND_TRUNCATED;
        end else begin
          phase_next = PH_DLO;
        end
      end
      PH_DLO: begin
        pending_delay_next = {held_high_byte_next, data_byte};
        if (last_byte) begin
          emit = 1'b1;
          kind = KIND_TRUNCATED;
        end else begin
          phase_next        = PH_PIX;
          byte_counter_next = '0;
        end
      end
      PH_PIX: begin
        emit = 1'b1;
        if (is_last) begin
          kind                  = KIND_PIXEL;
          pix                   = data_byte;
          ff                    = (byte_counter_next == '0);
          fl                    = 1'b1;
          time_accumulator_next = time_accumulator_next + 32'(pending_delay_next);
          phase_next            = PH_TYPE;
          byte_counter_next     = '0;
          if (last_byte) begin
            phase_next = repeat_enable ? PH_TYPE : PH_IDLE;
            rew        = repeat_enable;
          end
        end else if (last_byte) begin
          kind = KIND_TRUNCATED;
        end else begin
          kind              = KIND_PIXEL;
          pix               = data_byte;
          ff                = (byte_counter_next == '0);
          byte_counter_next = byte_counter_next + CntW'(1);
        end
      end
      default: begin
      end
    endcase

    // End of animation or truncation: replay or go quiet.
    if (kind == KIND_ANIM_END || kind == KIND_TRUNCATED) begin
      phase_next        = repeat_enable ? PH_TYPE : PH_IDLE;
      byte_counter_next = '0;
      rew               = repeat_enable;
    end
  end

  // State advances only on an accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      byte_counter     <= '0;
      header_valid     <= 1'b1;
      held_high_byte   <= '0;
      colour_depth     <= '0;
      bytes_per_pixel  <= '0;
      pending_delay    <= '0;
      time_accumulator <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      byte_counter     <= byte_counter_next;
      header_valid     <= header_valid_next;
      held_high_byte   <= held_high_byte_next;
      colour_depth     <= colour_depth_next;
      bytes_per_pixel  <= bytes_per_pixel_next;
      pending_delay    <= pending_delay_next;
      time_accumulator <= time_accumulator_next;
    end
  end

  // Result word for the output stage.
  assign res_valid          = accept && emit;
  assign res.kind           = kind;
  assign res.pixel_byte     = pix;
  assign res.frame_first    = ff;
  assign res.frame_last     = fl;
  assign res.show_time      = show;
  assign res.pixel_bytes    = bytes_per_pixel_next;
  assign res.colour_bits    = colour_depth_next;
  assign res.rewind_request = rew;

endmodule

// ===== src/lasp_out_stage.sv =====
// Output register with a skid register, so the input ready is a flop output.
// Depends on lasp_pkg for the result word.
module lasp_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lasp_pkg::lasp_result_t push_data,
  output logic                  push_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lasp_pkg::lasp_result_t out_data
);
  import lasp_pkg::*;

  logic         main_valid;
  logic         skid_valid;
  lasp_result_t main_word;
  lasp_result_t skid_word;
  logic         main_load;

  // The main register loads whenever it is empty or its word is taken.
  assign main_load  = !main_valid || out_ready;
  assign push_ready = !skid_valid;
  assign out_valid  = main_valid;
  assign out_data   = main_word;

  // Occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_load) begin
      main_valid <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload moves with occupancy; no reset needed.
  always_ff @(posedge clk) begin
    if (main_load) begin
      if (skid_valid) begin
        main_word <= skid_word;
        skid_word <= push_data;
      end else begin
        main_word <= push_data;
      end
    end else if (push) begin
      skid_word <= push_data;
    end
  end

endmodule

// ===== src/led_animation_stream_parser.sv =====
// LED animation stream parser, top level. A result word is registered in the output or
// skid register once its byte is accepted. Throughput: one byte per cycle while the output
// stage is ready; the decode is a single pass between the parser state and the output register.
// Reset (rst, synchronous, active high) clears the parser to the header phase,
// sets repeat_enable to 1 and empties the output register and skid register.
module led_animation_stream_parser #(
  parameter int MATRIX_WIDTH  = 8,
  parameter int MATRIX_HEIGHT = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  lasp_byte_if.sink            data,
  lasp_result_if.source        result,
  input  logic                 cfg_write,
  input  logic                 cfg_data
);
  import lasp_pkg::*;

  logic         repeat_enable;
  logic         accept;
  logic         res_valid;
  logic         stage_ready;
  lasp_result_t res_word;
  lasp_result_t out_word;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_enable <= 1'b1;
    end else if (cfg_write) begin
      repeat_enable <= cfg_data;
    end
  end

  assign data.ready = stage_ready;
  assign accept     = data.valid && stage_ready;

  lasp_parser #(
    .MATRIX_WIDTH  (MATRIX_WIDTH),
    .MATRIX_HEIGHT (MATRIX_HEIGHT)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data.data_byte),
    .first_byte    (data.first_byte),
    .last_byte     (data.last_byte),
    .repeat_enable (repeat_enable),
    .res_valid     (res_valid),
    .res           (res_word)
  );

  lasp_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res_word),
    .push_ready (stage_ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_data   (out_word)
  );

  // Unpack the result word onto the channel.
  assign result.result_kind    = out_word.kind;
  assign result.pixel_byte     = out_word.pixel_byte;
  assign result.frame_first    = out_word.frame_first;
  assign result.frame_last     = out_word.frame_last;
  assign result.show_time      = out_word.show_time;
  assign result.pixel_bytes    = out_word.pixel_bytes;
  assign result.colour_bits    = out_word.colour_bits;
  assign result.rewind_request = out_word.rewind_request;

endmodule

// ===== src/lasp_checker.sv =====
// Port-level checks for the LED animation stream parser, bound to the top level.
// Depends on lasp_pkg for the result kind codes.
module lasp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  result_kind,
  input logic        frame_first,
  input logic        frame_last,
  input logic [31:0] show_time,
  input logic [2:0]  pixel_bytes,
  input logic [4:0]  colour_bits
);
  import lasp_pkg::*;

  // No word is offered right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word offered right after reset");

  // A stalled word stays offered with its kind and show time unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(show_time))
    else $error("stalled result word changed");

  // Frame marks only come with pixel words.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_first || frame_last) |-> result_kind == KIND_PIXEL)
    else $error("frame mark on a non-pixel word");

  // An accepted header carries a legal pixel size and colour depth.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_HDR_OK |->
      (pixel_bytes == 3'd1 || pixel_bytes == 3'd2 || pixel_bytes == 3'd3 ||
       pixel_bytes == 3'd6) && colour_bits >= 5'd2 && colour_bits <= 5'd16)
    else $error("accepted header with bad pixel size or depth");

  // A rejected header reports cleared format fields.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_HDR_REJECT |-> pixel_bytes == 3'd0 && colour_bits == 5'd0)
    else $error("rejected header with format fields set");

endmodule

bind led_animation_stream_parser lasp_checker u_lasp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .result_kind (result.result_kind),
  .frame_first (result.frame_first),
  .frame_last  (result.frame_last),
  .show_time   (result.show_time),
  .pixel_bytes (result.pixel_bytes),
  .colour_bits (result.colour_bits)
);
